// ----- rtl/usb_capture_to_pcap_reframer_core_assert.svh -----
// Assertion macros shared by the reframer RTL.
// Included by the top level to check its own logic; no other dependencies.
`ifndef USB_CAPTURE_TO_PCAP_REFRAMER_CORE_ASSERT_SVH
`define USB_CAPTURE_TO_PCAP_REFRAMER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define UCPR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define UCPR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define UCPR_ASSERT(lbl, clk, rst_n, prop, msg)
`define UCPR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- rtl/ucpr_pkg.sv -----
// Shared types, constants and byte tables of the capture-to-pcap reframer.
// No dependencies; imported by ucpr_ns_div and the top level.
package ucpr_pkg;

  localparam logic [15:0] MAX_LEN_RESET = 16'h7fff;
  localparam logic [7:0]  EVENT_MARK    = 8'hff;
  localparam logic [7:0]  EVENT_TICKS   = 8'h00;

  localparam int unsigned GHDR_BYTES = 24;
  localparam int unsigned REC_BYTES  = 16;
  localparam int unsigned SEQ_CNT_W  = $clog2(GHDR_BYTES);

  // Seconds come from count*100 / 6e9: a reciprocal estimate from the upper
  // 32 bits is low by at most two, so two compare and subtract steps finish it.
  // The remainder divided by 6 gives the nanoseconds.
  localparam int unsigned         TS_REM_W      = 35;
  localparam logic [31:0]         TS_RECIP      = 32'd3074457345;  // floor(2^64 / 6e9)
  localparam logic [31:0]         TS_HALF_SEC   = 32'd3000000000;  // 6e9 / 2
  localparam logic [TS_REM_W-1:0] TS_ONE_SEC    = 35'd6000000000;
  localparam logic [TS_REM_W-1:0] TS_TWO_SEC    = 35'd12000000000;
  // x / 3 == (x * RECIP3) >> 33 for every 32-bit x
  localparam logic [31:0] RECIP3 = 32'haaaaaaab;

  typedef enum logic [1:0] {
    KIND_PCAP   = 2'd0,
    KIND_NOTICE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_PAD     = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_GHDR,
    SEQ_DIV,
    SEQ_REC
  } seq_e;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_EST,
    DIV_BACK,
    DIV_REM,
    DIV_FIX,
    DIV_RECIP,
    DIV_DONE
  } div_state_e;

  typedef struct packed {
    logic        done;
    logic [31:0] sec;
    logic [31:0] nsec;
  } div_res_t;

  function automatic logic [7:0] ghdr_byte(input logic [SEQ_CNT_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = 8'ha1;
      5'd1:    b = 8'hb2;
      5'd2:    b = 8'h3c;
      5'd3:    b = 8'h4d;
      5'd5:    b = 8'h02;
      5'd7:    b = 8'h04;
      5'd18:   b = 8'hff;
      5'd19:   b = 8'hff;
      5'd22:   b = 8'h01;
      5'd23:   b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Record: seconds, nanoseconds, length, length; each 32-bit big-endian.
  function automatic logic [7:0] rec_byte(input logic [31:0] sec, input logic [31:0] nsec,
                                          input logic [15:0] len, input logic [3:0] idx);
    logic [31:0] w;
    logic [7:0]  b;
    unique case (idx[3:2])
      2'd0:    w = sec;
      2'd1:    w = nsec;
      default: w = {16'h0000, len};
    endcase
    unique case (idx[1:0])
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/ucpr_ns_div.sv -----
// Timestamp unit: 60 MHz tick count to pcap seconds and nanoseconds.
// Multi-cycle: shift-add x100, reciprocal estimate with correction, reciprocal /3.
// Uses ucpr_pkg.
module ucpr_ns_div import ucpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] count_i,
  output div_res_t    res_o
);

  div_state_e state_q, state_d;

  logic [63:0]         cnt_q;
  logic [63:0]         ticks_x100_q;
  logic [31:0]         sec_q, sec_d;
  logic [63:0]         sec_mul_q;
  logic [TS_REM_W-1:0] rem_q, rem_d;
  logic [63:0]         prod_q;
  logic [63:0]         est_prod;
  logic [63:0]         back_prod;
  logic [63:0]         nsec_prod;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE:  if (start_i) state_d = DIV_MUL;
      DIV_MUL:   state_d = DIV_EST;
      DIV_EST:   state_d = DIV_BACK;
      DIV_BACK:  state_d = DIV_REM;
      DIV_REM:   state_d = DIV_FIX;
      DIV_FIX:   state_d = DIV_RECIP;
      DIV_RECIP: state_d = DIV_DONE;
      default:   state_d = DIV_IDLE;
    endcase
  end

  // Estimate from the upper word never overshoots and is short by at most two.
  assign est_prod  = ticks_x100_q[63:32] * TS_RECIP;
  // Estimate times 6e9, taken as times 3e9 and shifted once.
  assign back_prod = sec_q * TS_HALF_SEC;

  always_comb begin
    priority if (rem_q >= TS_TWO_SEC) begin
      sec_d = sec_q + 32'd2;
      rem_d = rem_q - TS_TWO_SEC;
    end else if (rem_q >= TS_ONE_SEC) begin
      sec_d = sec_q + 32'd1;
      rem_d = rem_q - TS_ONE_SEC;
    end else begin
      sec_d = sec_q;
      rem_d = rem_q;
    end
  end

  // Remainder is below 6e9, so half of it fits 32 bits.
  assign nsec_prod = rem_q[32:1] * RECIP3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DIV_IDLE:  if (start_i) cnt_q <= count_i;
      DIV_MUL:   ticks_x100_q <= (cnt_q << 6) + (cnt_q << 5) + (cnt_q << 2);
      DIV_EST:   sec_q <= est_prod[63:32];
      DIV_BACK:  sec_mul_q <= back_prod;
      DIV_REM:   rem_q <= TS_REM_W'(ticks_x100_q - {sec_mul_q[62:0], 1'b0});
      DIV_FIX: begin
        sec_q <= sec_d;
        rem_q <= rem_d;
      end
      DIV_RECIP: prod_q <= nsec_prod;
      default: ;
    endcase
  end

  always_comb begin
    res_o.done = (state_q == DIV_DONE);
    res_o.sec  = sec_q;
    res_o.nsec = 32'(prod_q[63:33]);
  end

endmodule

// ----- rtl/usb_capture_to_pcap_reframer_core.sv -----
// Top level of the capture-to-pcap reframer: input register, header parser,
// burst sequencer and output register. Uses ucpr_pkg and ucpr_ns_div.
//
//  channel  | dir | tdata          | tuser    | tlast
//  ---------+-----+----------------+----------+----------------------
//  s_axis   | in  | in_byte [7:0]  | cmd      | -
//  m_axis   | out | out_byte [7:0] | kind[1:0]| last result of a beat
//  cfg      | in  | max_packet_length [15:0], valid/ready only
//
// Payload beats: one result per cycle unless the output stalls; header and
// pad beats give none but a notice or error. Start command: 24-byte header,
// input held meanwhile. Packet header: timestamp unit (x100, estimate,
// back multiply, subtract, correct, divide by 6, done), then 16-byte record.
// Output stalls hold the output register and back up through the input
// register. Reset clears all control state; no clearing pass.
module usb_capture_to_pcap_reframer_core import ucpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] in_byte
  input  logic        s_axis_tuser_i,  // [0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_byte
  output logic [1:0]  m_axis_tuser_o,  // [1:0] kind
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i       // [15:0] max_packet_length
);

  logic [15:0] max_len_q;

  logic       in_valid_q;
  logic       in_cmd_q;
  logic [7:0] in_byte_q;

  phase_e      phase_q, phase_d;
  logic [1:0]  hdr_idx_q, hdr_idx_d;
  logic [7:0]  hdr_q [3];
  logic [7:0]  hdr_d [3];
  logic [15:0] remaining_q, remaining_d;
  logic        pad_q, pad_d;
  logic [63:0] clk_cnt_q, clk_cnt_d;
  logic        halted_q, halted_d;
  logic [15:0] len_q, len_d;

  seq_e                 seq_q, seq_d;
  logic [SEQ_CNT_W-1:0] seq_cnt_q;

  logic        m_valid_q;
  logic [7:0]  m_data_q;
  kind_e       m_user_q;
  logic        m_last_q;

  logic        out_free;
  logic        advance;
  logic        produces;
  logic        launch_ghdr;
  logic        launch_rec;
  logic [7:0]  direct_byte;
  kind_e       direct_kind;
  logic        seq_emit;
  logic [7:0]  seq_byte;
  logic        seq_last;
  logic [15:0] hdr_len;
  logic [63:0] clk_sum;
  div_res_t    div_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && (seq_q == SEQ_IDLE) && (out_free || !produces);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_cmd_q  <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
  end

  assign hdr_len = {hdr_q[0], hdr_q[1]};
  assign clk_sum = clk_cnt_q + 64'({hdr_q[2], in_byte_q});

  // State update of the beat in the input register, applied on advance.
  always_comb begin
    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    hdr_d       = hdr_q;
    remaining_d = remaining_q;
    pad_d       = pad_q;
    clk_cnt_d   = clk_cnt_q;
    halted_d    = halted_q;
    len_d       = len_q;
    produces    = 1'b0;
    launch_ghdr = 1'b0;
    launch_rec  = 1'b0;
    direct_byte = in_byte_q;
    direct_kind = KIND_PCAP;
    if (halted_q) begin
      // drop everything until reset
    end else if (!in_cmd_q) begin
      launch_ghdr = 1'b1;
    end else begin
      unique case (phase_q)
        PH_PAYLOAD: begin
          produces    = 1'b1;
          remaining_d = remaining_q - 1'b1;
          if (remaining_q == 16'd1) begin
            phase_d = pad_q ? PH_PAD : PH_HEADER;
          end
        end
        PH_PAD: begin
          pad_d   = 1'b0;
          phase_d = PH_HEADER;
        end
        default: begin
          phase_d = PH_HEADER;
          if (hdr_idx_q != 2'd3) begin
            hdr_d[hdr_idx_q] = in_byte_q;
            hdr_idx_d        = hdr_idx_q + 1'b1;
          end else begin
            hdr_idx_d = 2'd0;
            if (hdr_q[0] == EVENT_MARK) begin
              if (hdr_q[1] == EVENT_TICKS) begin
                clk_cnt_d = clk_sum;
              end else begin
                produces    = 1'b1;
                direct_byte = hdr_q[1];
                direct_kind = KIND_NOTICE;
              end
            end else if (hdr_len > max_len_q) begin
              halted_d    = 1'b1;
              produces    = 1'b1;
              direct_byte = 8'h00;
              direct_kind = KIND_ERROR;
            end else begin
              clk_cnt_d  = clk_sum;
              len_d      = hdr_len;
              launch_rec = 1'b1;
              if (hdr_len != 16'd0) begin
                phase_d     = PH_PAYLOAD;
                remaining_d = hdr_len;
                pad_d       = hdr_len[0];
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_idx_q   <= 2'd0;
      remaining_q <= 16'd0;
      pad_q       <= 1'b0;
      clk_cnt_q   <= 64'd0;
      halted_q    <= 1'b0;
    end else if (advance) begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      remaining_q <= remaining_d;
      pad_q       <= pad_d;
      clk_cnt_q   <= clk_cnt_d;
      halted_q    <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hdr_q <= hdr_d;
      len_q <= len_d;
    end
  end

  ucpr_ns_div u_ns_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (advance && launch_rec),
    .count_i (clk_sum),
    .res_o   (div_res)
  );

  // Burst sequencer: next state
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE: begin
        if (advance && launch_ghdr) begin
          seq_d = SEQ_GHDR;
        end else if (advance && launch_rec) begin
          seq_d = SEQ_DIV;
        end
      end
      SEQ_GHDR: if (out_free && seq_cnt_q == SEQ_CNT_W'(GHDR_BYTES - 1)) seq_d = SEQ_IDLE;
      SEQ_DIV:  if (div_res.done) seq_d = SEQ_REC;
      default:  if (out_free && seq_cnt_q == SEQ_CNT_W'(REC_BYTES - 1)) seq_d = SEQ_IDLE;
    endcase
  end

  // Burst sequencer: outputs
  always_comb begin
    seq_emit = 1'b0;
    seq_byte = ghdr_byte(seq_cnt_q);
    seq_last = 1'b0;
    unique case (seq_q)
      SEQ_GHDR: begin
        seq_emit = out_free;
        seq_last = (seq_cnt_q == SEQ_CNT_W'(GHDR_BYTES - 1));
      end
      SEQ_REC: begin
        seq_emit = out_free;
        seq_byte = rec_byte(div_res.sec, div_res.nsec, len_q, seq_cnt_q[3:0]);
        seq_last = (seq_cnt_q == SEQ_CNT_W'(REC_BYTES - 1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q     <= SEQ_IDLE;
      seq_cnt_q <= '0;
    end else begin
      seq_q <= seq_d;
      if (seq_q == SEQ_IDLE || seq_q == SEQ_DIV) begin
        seq_cnt_q <= '0;
      end else if (seq_emit) begin
        seq_cnt_q <= seq_cnt_q + 1'b1;
      end
    end
  end

  // Output register; a direct result and a burst never load in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if ((advance && produces) || seq_emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_emit) begin
      m_data_q <= seq_byte;
      m_user_q <= KIND_PCAP;
      m_last_q <= seq_last;
    end else if (advance && produces) begin
      m_data_q <= direct_byte;
      m_user_q <= direct_kind;
      m_last_q <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

`include "usb_capture_to_pcap_reframer_core_assert.svh"

  `UCPR_ASSERT(a_halt_sticky, clk_i, rst_ni, halted_q |=> halted_q, "halt released before reset")
  `UCPR_ASSERT(a_halt_error, clk_i, rst_ni,
               $rose(halted_q) |-> m_valid_q && (m_user_q == KIND_ERROR),
               "halt without error beat")
  `UCPR_ASSERT(a_div_done_wait, clk_i, rst_ni, div_res.done |-> (seq_q == SEQ_DIV),
               "timestamp done while not waiting")
  `UCPR_ASSERT_NEVER(a_payload_cnt, clk_i, rst_ni,
                     (phase_q == PH_PAYLOAD) && (remaining_q == 16'd0),
                     "payload phase with no bytes left")

endmodule
